[hw/rtl/packet_airtime_calc_macros.svh]
// Assertion helpers; clk_i and rst_ni must be in scope.
`ifndef PACKET_AIRTIME_CALC_MACROS_SVH
`define PACKET_AIRTIME_CALC_MACROS_SVH

// same-cycle implication
`define PAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pac_pkg.sv]
package pac_pkg;

  localparam int unsigned LenW     = 8;
  localparam int unsigned AirW     = 26;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BwCodeW  = 4;
  localparam int unsigned SfW      = 4;
  localparam int unsigned CrW      = 3;
  localparam int unsigned PreW     = 16;
  localparam int unsigned RecipW   = 32;
  localparam int unsigned SfRecipW = 16;

  localparam logic [CfgIdxW-1:0] CFG_BW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SF  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CR  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRE = 2'd3;

  localparam logic [BwCodeW-1:0] BW_RST  = 4'd9;
  localparam logic [SfW-1:0]     SF_RST  = 4'd7;
  localparam logic [CrW-1:0]     CR_RST  = 3'd1;
  localparam logic [PreW-1:0]    PRE_RST = 16'd6;

  localparam logic [SfW-1:0] SF_MIN = 4'd6;
  localparam logic [SfW-1:0] SF_MAX = 4'd12;

  // derived settings; the user must keep them fixed while items are in flight, the block does not enforce it
  typedef struct packed {
    logic [SfW-1:0]      sf;
    logic [2:0]          bw_shift;
    logic [6:0]          bw_odd;
    logic [RecipW-1:0]   odd_recip;
    logic [SfRecipW-1:0] sf_recip;
    logic [3:0]          cr_mult;
    logic [PreW-1:0]     preamble;
  } pac_params_t;

  // bandwidth in kHz = (1 << shift) * odd
  function automatic logic [2:0] bw_shift(input logic [BwCodeW-1:0] code);
    logic [2:0] s;
    case (code)
      4'd0:    s = 3'd3;
      4'd2:    s = 3'd4;
      4'd4:    s = 3'd5;
      4'd5:    s = 3'd1;
      4'd8:    s = 3'd1;
      4'd9:    s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] bw_odd(input logic [BwCodeW-1:0] code);
    logic [6:0] o;
    case (code)
      4'd0, 4'd2, 4'd4: o = 7'd1;
      4'd1:             o = 7'd11;
      4'd3, 4'd5:       o = 7'd21;
      4'd6:             o = 7'd63;
      default:          o = 7'd125;
    endcase
    return o;
  endfunction

  // floor((2^32 - 1) / odd)
  function automatic logic [RecipW-1:0] odd_recip(input logic [6:0] odd);
    logic [RecipW-1:0] m;
    case (odd)
      7'd1:    m = 32'hFFFF_FFFF;
      7'd11:   m = 32'd390451572;
      7'd21:   m = 32'd204522252;
      7'd63:   m = 32'd68174084;
      default: m = 32'd34359738;
    endcase
    return m;
  endfunction

  // floor(2^16 / sf)
  function automatic logic [SfRecipW-1:0] sf_recip(input logic [SfW-1:0] sf);
    logic [SfRecipW-1:0] m;
    case (sf)
      4'd6:    m = 16'd10922;
      4'd7:    m = 16'd9362;
      4'd8:    m = 16'd8192;
      4'd9:    m = 16'd7281;
      4'd10:   m = 16'd6553;
      4'd11:   m = 16'd5957;
      default: m = 16'd5461;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/pac_in_if.sv]
interface pac_in_if;
  logic                       valid;
  logic                       ready;
  logic [pac_pkg::LenW-1:0]   payload_bytes;

  modport source (output valid, output payload_bytes, input ready);
  modport sink   (input valid, input payload_bytes, output ready);
endinterface

[hw/rtl/pac_out_if.sv]
interface pac_out_if;
  logic                       valid;
  logic                       ready;
  logic [pac_pkg::AirW-1:0]   airtime_ms;

  modport source (output valid, output airtime_ms, input ready);
  modport sink   (input valid, input airtime_ms, output ready);
endinterface

[hw/rtl/pac_cfg_regs.sv]
module pac_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pac_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pac_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output pac_pkg::pac_params_t           params_o
);

  logic [pac_pkg::BwCodeW-1:0] bw_q;
  logic [pac_pkg::SfW-1:0]     sf_q;
  logic [pac_pkg::CrW-1:0]     cr_q;
  logic [pac_pkg::PreW-1:0]    pre_q;
  logic [pac_pkg::SfW-1:0]     sf_clamped;
  logic [6:0]                  odd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q  <= pac_pkg::BW_RST;
      sf_q  <= pac_pkg::SF_RST;
      cr_q  <= pac_pkg::CR_RST;
      pre_q <= pac_pkg::PRE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pac_pkg::CFG_BW:  bw_q  <= cfg_wdata_i[pac_pkg::BwCodeW-1:0];
        pac_pkg::CFG_SF:  sf_q  <= cfg_wdata_i[pac_pkg::SfW-1:0];
        pac_pkg::CFG_CR:  cr_q  <= cfg_wdata_i[pac_pkg::CrW-1:0];
        pac_pkg::CFG_PRE: pre_q <= cfg_wdata_i[pac_pkg::PreW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sf_q < pac_pkg::SF_MIN) begin
      sf_clamped = pac_pkg::SF_MIN;
    end else if (sf_q > pac_pkg::SF_MAX) begin
      sf_clamped = pac_pkg::SF_MAX;
    end else begin
      sf_clamped = sf_q;
    end
  end

  assign odd = pac_pkg::bw_odd(bw_q);

  assign params_o.sf        = sf_clamped;
  assign params_o.bw_shift  = pac_pkg::bw_shift(bw_q);
  assign params_o.bw_odd    = odd;
  assign params_o.odd_recip = pac_pkg::odd_recip(odd);
  assign params_o.sf_recip  = pac_pkg::sf_recip(sf_clamped);
  assign params_o.cr_mult   = 4'({1'b0, cr_q}) + 4'd4;
  assign params_o.preamble  = pre_q;

endmodule

[hw/rtl/packet_airtime_calc.sv]
// Each accepted input beat passes through stage registers 1 to 6 in order before its result shows on out_o.
// Throughput: one beat per cycle while out_o.ready holds; six register stages, each with its own
// valid bit, and a stalled stage only holds back the stages before it.
// Reset (rst_ni low, asynchronous) empties the pipe and loads the default
// settings: bandwidth code 9, spreading factor 7, coding rate 1, preamble 6.
`include "packet_airtime_calc_macros.svh"

module packet_airtime_calc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pac_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pac_pkg::CfgDataW-1:0]   cfg_wdata_i,
  pac_in_if.sink                         in_i,
  pac_out_if.source                      out_o
);

  pac_pkg::pac_params_t prm;

  pac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .params_o    (prm)
  );

  logic [6:1] stg_en;
  logic       s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, out_vld_q;

  // stage 1 operands
  logic [11:0] num, sub, dv;
  logic [9:0]  sym_d;
  logic [18:0] pre_n;
  logic [30:0] pre_sh;
  logic [28:0] pre_y_d;
  logic [28:0] s1_pre_y_q;
  logic [9:0]  s1_sym_q;

  // stage 2 reciprocal products
  logic [60:0] pre_prod;
  logic [25:0] sym_prod;
  logic [28:0] s2_pre_y_q, s2_pre_q0_q;
  logic [9:0]  s2_sym_q, s2_sym_q0_q;

  // stage 3 corrections
  logic [28:0] pre_r, tpre_d;
  logic [9:0]  sym_r, ct_d;
  logic [25:0] s3_tpre_q;
  logic [6:0]  s3_ct_q;

  // stage 4 symbol count and scaling
  logic [9:0]  ns;
  logic [21:0] pay_sh, pay_z_d;
  logic [21:0] s4_pay_z_q;
  logic [25:0] s4_tpre_q;

  // stage 5 reciprocal product
  logic [53:0] pay_prod;
  logic [21:0] s5_pay_z_q, s5_pay_q0_q;
  logic [25:0] s5_tpre_q;

  // stage 6 correction and sum
  logic [21:0] pay_r, tpay;
  logic [pac_pkg::AirW-1:0] out_d, out_q;

  // a stage may load when it is empty or its contents move on
  assign stg_en[6] = !out_vld_q || out_o.ready;
  assign stg_en[5] = !s5_vld_q || stg_en[6];
  assign stg_en[4] = !s4_vld_q || stg_en[5];
  assign stg_en[3] = !s3_vld_q || stg_en[4];
  assign stg_en[2] = !s2_vld_q || stg_en[3];
  assign stg_en[1] = !s1_vld_q || stg_en[2];

  assign in_i.ready = stg_en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (stg_en[1]) begin
        s1_vld_q <= in_i.valid;
      end
      if (stg_en[2]) begin
        s2_vld_q <= s1_vld_q;
      end
      if (stg_en[3]) begin
        s3_vld_q <= s2_vld_q;
      end
      if (stg_en[4]) begin
        s4_vld_q <= s3_vld_q;
      end
      if (stg_en[5]) begin
        s5_vld_q <= s4_vld_q;
      end
      if (stg_en[6]) begin
        out_vld_q <= s5_vld_q;
      end
    end
  end

  // stage 1: ceiling numerator over four, preamble chips over 4 * 2^shift
  always_comb begin
    num    = 12'({in_i.payload_bytes, 3'b000}) + 12'd44;
    dv     = 12'({prm.sf, 2'b00});
    sub    = dv + ((prm.sf == pac_pkg::SF_MIN) ? 12'd20 : 12'd0);
    if (num > sub) begin
      sym_d = 10'((num - sub + dv - 12'd1) >> 2);
    end else begin
      sym_d = 10'd0;
    end
    pre_n   = 19'({prm.preamble, 2'b00}) + 19'd17;
    pre_sh  = 31'(pre_n) << prm.sf;
    pre_y_d = 29'(pre_sh >> (4'd2 + 4'(prm.bw_shift)));
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[1] && in_i.valid) begin
      s1_pre_y_q <= pre_y_d;
      s1_sym_q   <= sym_d;
    end
  end

  // stage 2: quotient estimates, low by at most one
  assign pre_prod = 61'(s1_pre_y_q) * 61'(prm.odd_recip);
  assign sym_prod = 26'(s1_sym_q) * 26'(prm.sf_recip);

  always_ff @(posedge clk_i) begin
    if (stg_en[2] && s1_vld_q) begin
      s2_pre_y_q  <= s1_pre_y_q;
      s2_pre_q0_q <= pre_prod[60:32];
      s2_sym_q    <= s1_sym_q;
      s2_sym_q0_q <= sym_prod[25:16];
    end
  end

  // stage 3: one compare-and-add fix-up
  always_comb begin
    pre_r  = s2_pre_y_q - 29'(s2_pre_q0_q * 29'(prm.bw_odd));
    tpre_d = s2_pre_q0_q + ((pre_r >= 29'(prm.bw_odd)) ? 29'd1 : 29'd0);
    sym_r  = s2_sym_q - 10'(s2_sym_q0_q * 10'(prm.sf));
    ct_d   = s2_sym_q0_q + ((sym_r >= 10'(prm.sf)) ? 10'd1 : 10'd0);
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[3] && s2_vld_q) begin
      s3_tpre_q <= tpre_d[25:0];
      s3_ct_q   <= ct_d[6:0];
    end
  end

  // stage 4: payload symbols, chips over 2^shift
  always_comb begin
    ns      = 10'd9 + 10'(11'(s3_ct_q) * 11'(prm.cr_mult));
    pay_sh  = 22'(ns) << prm.sf;
    pay_z_d = pay_sh >> prm.bw_shift;
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[4] && s3_vld_q) begin
      s4_pay_z_q <= pay_z_d;
      s4_tpre_q  <= s3_tpre_q;
    end
  end

  // stage 5
  assign pay_prod = 54'(s4_pay_z_q) * 54'(prm.odd_recip);

  always_ff @(posedge clk_i) begin
    if (stg_en[5] && s4_vld_q) begin
      s5_pay_z_q  <= s4_pay_z_q;
      s5_pay_q0_q <= pay_prod[53:32];
      s5_tpre_q   <= s4_tpre_q;
    end
  end

  // stage 6
  always_comb begin
    pay_r = s5_pay_z_q - 22'(s5_pay_q0_q * 22'(prm.bw_odd));
    tpay  = s5_pay_q0_q + ((pay_r >= 22'(prm.bw_odd)) ? 22'd1 : 22'd0);
    out_d = s5_tpre_q + pac_pkg::AirW'(tpay);
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[6] && s5_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.airtime_ms = out_q;

  `PAC_ASSERT_NXT(a_accept_fills_s1, in_i.valid && in_i.ready, s1_vld_q, "accepted beat lost")
  `PAC_ASSERT_NOW(a_pre_fixup, s2_vld_q, pre_r < (29'(prm.bw_odd) + 29'(prm.bw_odd)), "preamble quotient off by more than one")
  `PAC_ASSERT_NOW(a_sym_fixup, s2_vld_q, sym_r < (10'(prm.sf) + 10'(prm.sf)), "symbol quotient off by more than one")
  `PAC_ASSERT_NOW(a_pay_fixup, s5_vld_q, pay_r < (22'(prm.bw_odd) + 22'(prm.bw_odd)), "payload quotient off by more than one")

endmodule
